// ===== src/i2cm_pkg.sv =====
// Package for the I2C master byte engine: item structs, opcodes, command
// modes and the engine state record. No dependencies.
package i2cm_pkg;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [1:0] PH_SETUP = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;

	localparam logic [3:0] ACK_SLOT = 4'd8;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_START,
		MODE_STOP,
		MODE_WRITE,
		MODE_READ
	} mode_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_level;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic [7:0] rx_byte;
		logic       nack_seen;
		logic       done_res;
		logic       busy_res;
	} out_item_t;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] phase;
		logic [3:0] bit_cnt;
		logic [7:0] shift;
		logic       ack_choice;
		logic       nack_flag;
		logic       clock_out;
		logic       data_out;
		logic [7:0] rx_hold;
	} state_t;

endpackage

// ===== src/i2cm_step.sv =====
// Next-state logic of the I2C master byte engine: command load and at most one line
// phase advance per item. Depends on i2cm_pkg.
module i2cm_step (
	input  i2cm_pkg::state_t   cur,
	input  i2cm_pkg::in_item_t item,
	output i2cm_pkg::state_t   nxt,
	output logic               fin
);
	import i2cm_pkg::*;

	state_t     wk;
	state_t     adv;
	logic       run;
	logic [1:0] ph;
	logic       ack_slot;
	logic       wr;

	// load a new command while idle
	always_comb begin
		wk  = cur;
		run = 1'b1;
		if (cur.mode == MODE_IDLE) begin
			wk.phase   = PH_SETUP;
			wk.bit_cnt = '0;
			unique case (item.opcode)
				OP_START: wk.mode = MODE_START;
				OP_STOP:  wk.mode = MODE_STOP;
				OP_WRITE: begin
					wk.mode  = MODE_WRITE;
					wk.shift = item.tx_byte;
				end
				OP_READ: begin
					wk.mode       = MODE_READ;
					wk.shift      = '0;
					wk.ack_choice = item.send_ack;
				end
				default: run = 1'b0;
			endcase
		end
	end

	assign ph       = (wk.phase == 2'd3) ? PH_SETUP : wk.phase;
	assign ack_slot = (wk.bit_cnt >= ACK_SLOT);
	assign wr       = (wk.mode == MODE_WRITE);

	// advance one line phase
	always_comb begin
		adv = wk;
		fin = 1'b0;
		if (run) begin
			unique case (wk.mode)
				MODE_START: begin
					case (ph)
						PH_SETUP: begin
							adv.clock_out = 1'b1;
							adv.data_out  = 1'b1;
						end
						PH_HIGH: adv.data_out = 1'b0;
						default: begin
							adv.clock_out = 1'b0;
							fin           = 1'b1;
						end
					endcase
				end
				MODE_STOP: begin
					case (ph)
						PH_SETUP: adv.data_out  = 1'b0;
						PH_HIGH:  adv.clock_out = 1'b1;
						default: begin
							adv.data_out = 1'b1;
							fin          = 1'b1;
						end
					endcase
				end
				default: begin
					case (ph)
						PH_SETUP: begin
							if (ack_slot)
								adv.data_out = wr | ~wk.ack_choice;
							else
								adv.data_out = wr ? wk.shift[7] : 1'b1;
						end
						PH_HIGH: adv.clock_out = 1'b1;
						default: begin
							adv.clock_out = 1'b0;
							if (ack_slot) begin
								if (wr) begin
									adv.nack_flag = item.sda_level;
								end else begin
									adv.data_out = 1'b1;
									adv.rx_hold  = wk.shift;
								end
								fin = 1'b1;
							end else begin
								adv.shift   = {wk.shift[6:0], wr ? 1'b0 : item.sda_level};
								adv.bit_cnt = wk.bit_cnt + 4'd1;
							end
						end
					endcase
				end
			endcase
			if (fin) begin
				adv.phase   = PH_SETUP;
				adv.bit_cnt = '0;
			end else begin
				adv.phase = (ph == PH_LOW) ? PH_SETUP : ph + 2'd1;
			end
		end
	end

	// drop back to idle at the end of a command or on an ignored item
	always_comb begin
		nxt = adv;
		if (!run || fin)
			nxt.mode = MODE_IDLE;
	end

endmodule

// ===== src/i2c_master_byte_engine.sv =====
// I2C master byte engine top level: input register, engine state, result register.
// An accepted item is held in the input register, and the result register loads from it;
// a stalled result holds the input register and stalls the next item.
// Throughput: one item per cycle unless the result stalls, the whole phase step sits between the
// input register and the result register.
// Reset: lines idle high, engine idle, no item held. Depends on i2cm_pkg, i2cm_step.
module i2c_master_byte_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  i2cm_pkg::in_item_t  cmd,
	output logic                res_valid,
	input  logic                res_stall,
	output i2cm_pkg::out_item_t res
);
	import i2cm_pkg::*;

	logic      valid_s1;
	in_item_t  cmd_s1;
	state_t    state_q;
	state_t    state_nxt;
	logic      fin;
	logic      fire;
	out_item_t res_q;
	logic      res_valid_q;

	assign cmd_stall = valid_s1 & res_valid_q & res_stall;
	assign fire      = valid_s1 & ~(res_valid_q & res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall)
			cmd_s1 <= cmd;
	end

	i2cm_step u_step (
		.cur  (state_q),
		.item (cmd_s1),
		.nxt  (state_nxt),
		.fin  (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_IDLE, phase: PH_SETUP, bit_cnt: '0, shift: '0,
				ack_choice: 1'b0, nack_flag: 1'b0, clock_out: 1'b1,
				data_out: 1'b1, rx_hold: '0};
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!(res_valid_q && res_stall)) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q.scl_level   <= state_nxt.clock_out;
			res_q.sda_release <= state_nxt.data_out;
			res_q.rx_byte     <= state_nxt.rx_hold;
			res_q.nack_seen   <= state_nxt.nack_flag;
			res_q.done_res    <= fin;
			res_q.busy_res    <= (state_nxt.mode != MODE_IDLE);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== src/i2cm_checker.sv =====
// Port checker for the I2C master byte engine and its bind to the top level.
// Depends on i2cm_pkg and i2c_master_byte_engine.
module i2cm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input i2cm_pkg::in_item_t  cmd,
	input logic                res_valid,
	input logic                res_stall,
	input i2cm_pkg::out_item_t res
);
	import i2cm_pkg::*;

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("stalled input item changed");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result item changed");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.done_res && res.busy_res))
		else $error("finished command still busy");

	a_start_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.done_res && !res.sda_release |-> !res.scl_level)
		else $error("command ended with SDA low and SCL high");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled without result backpressure");

endmodule

bind i2c_master_byte_engine i2cm_checker u_chk (.*);
